// File: src/sorted_priority_queue_assert.svh
// assertion macros used by the checker file
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, off during reset
`define SPQ_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SPQ_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int LEVEL_W      = 8;
    localparam int VALUE_W      = 32;
    localparam int ENTRY_W      = LEVEL_W + VALUE_W;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 48;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CMP,
        S_INS,
        S_POP,
        S_FIN
    } state_t;

endpackage

// File: src/spq_ram.sv
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/sorted_priority_queue.sv
// Bounded priority queue of CAPACITY entries kept in one RAM as a list sorted by
// level, highest first; a push goes behind every entry of equal or higher level,
// a pop takes the tail (lowest level, newest of those) and returns it. Every
// accepted input transfer yields exactly one output transfer with a status (ok,
// pop on empty, push on full) and the occupancy after the step. One item is in
// work at a time and s_tready is low meanwhile. States, from one accepted input
// transfer to the next possible one: a pop passes S_START (tail read), S_POP and
// S_FIN; a rejected push or pop and a push into an empty queue pass S_START and
// S_FIN; any other push passes S_START, S_CMP for each entry it looks at, S_INS
// if the walk reaches the head, and S_FIN. S_CMP is the insertion walk: the
// single RAM read port fetches one entry per cycle from the tail upward, and
// the one level comparator decides whether that entry moves down (written back
// one slot lower) or the new entry is written in place. A finished result sits
// in the output register until taken; a new item can be accepted while it waits.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input: tdata = {entry_value[39:8], entry_level[7:0]}
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spq_pkg::IN_TDATA_W-1:0]   s_tdata,
    // input: tuser = {action[0]}
    input  logic [0:0]                       s_tuser,
    // output: tdata = {pad[47:45], occupancy[44:40], removed_value[39:8],
    //                  removed_level[7:0]}
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // output: tuser = {status[1:0]}
    output logic [spq_pkg::STATUS_W-1:0]     m_tuser
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LW     = spq_pkg::LEVEL_W;
    localparam int VW     = spq_pkg::VALUE_W;
    localparam int EW     = spq_pkg::ENTRY_W;

    // sequencer state and the item in work
    spq_pkg::state_t state_reg, state_next;
    logic              action_reg, action_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [VW-1:0]     val_reg, val_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;     // slot the walk may write into
    logic [CNT_W-1:0]  count_reg, count_next;

    // result being built
    logic [spq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [LW-1:0]                res_level_reg, res_level_next;
    logic [VW-1:0]                res_value_reg, res_value_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [spq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [LW-1:0]                out_level_reg, out_level_next;
    logic [VW-1:0]                out_value_reg, out_value_next;
    logic [spq_pkg::OCC_W-1:0]    out_occ_reg, out_occ_next;

    // ram port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [EW-1:0]     wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [EW-1:0]     rd_data;

    logic          in_xfer;
    logic [31:0]   count_wide;
    logic [LW-1:0] rd_level;

    assign in_xfer    = s_tvalid && s_tready;
    assign rd_level   = rd_data[LW-1:0];
    assign count_wide = 32'(count_reg);

    // entry word: level in the low bits, value above
    spq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        lvl_reg        <= lvl_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_level_reg  <= res_level_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_level_reg  <= out_level_next;
        out_value_reg  <= out_value_next;
        out_occ_reg    <= out_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        lvl_next        = lvl_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_level_next  = res_level_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_level_next  = out_level_reg;
        out_value_next  = out_value_reg;
        out_occ_next    = out_occ_reg;
        s_tready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {val_reg, lvl_reg};
        rd_en           = 1'b0;
        rd_addr         = idx_reg - 1'b1;

        // output register drains independently of the sequencer
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (in_xfer)
                begin
                    action_next = s_tuser[0];
                    lvl_next    = s_tdata[LW-1:0];
                    val_next    = s_tdata[LW+VW-1:LW];
                    idx_next    = count_reg[ADDR_W-1:0];
                    state_next  = spq_pkg::S_START;
                end
            end

            spq_pkg::S_START:
            begin
                res_status_next = spq_pkg::ST_OK;
                res_level_next  = '0;
                res_value_next  = '0;
                if (action_reg == spq_pkg::ACT_POP)
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = spq_pkg::ST_EMPTY;
                        state_next      = spq_pkg::S_FIN;
                    end
                    else
                    begin
                        // fetch the tail entry
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(count_reg - 1'b1);
                        count_next = count_reg - 1'b1;
                        state_next = spq_pkg::S_POP;
                    end
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    res_status_next = spq_pkg::ST_FULL;
                    state_next      = spq_pkg::S_FIN;
                end
                else if (idx_reg == '0)
                begin
                    // empty list, new entry goes to the head
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = spq_pkg::S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = spq_pkg::S_CMP;
                end
            end

            spq_pkg::S_CMP:
            begin
                // rd_data holds slot idx-1
                if (rd_level < lvl_reg)
                begin
                    // move it down one slot and keep walking up
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == ADDR_W'(1))
                    begin
                        state_next = spq_pkg::S_INS;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = spq_pkg::S_FIN;
                end
            end

            spq_pkg::S_INS:
            begin
                // walk reached the head
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = spq_pkg::S_FIN;
            end

            spq_pkg::S_POP:
            begin
                res_level_next = rd_data[LW-1:0];
                res_value_next = rd_data[EW-1:LW];
                state_next     = spq_pkg::S_FIN;
            end

            spq_pkg::S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_level_next  = res_level_reg;
                    out_value_next  = res_value_reg;
                    out_occ_next    = count_wide[spq_pkg::OCC_W-1:0];
                    state_next      = spq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_value_reg, out_level_reg};

endmodule

// File: src/spq_checker.sv
`include "sorted_priority_queue_assert.svh"

module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [spq_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic [0:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [spq_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [spq_pkg::STATUS_W-1:0]     m_tuser
);

    logic [spq_pkg::OCC_W-1:0] occ;
    logic [31:0]               cap_wide;
    logic                      in_used;

    assign occ      = m_tdata[44:40];
    assign cap_wide = 32'(CAPACITY);
    // input fields are not checked, only tied into the watch list
    assign in_used  = ^{s_tdata, s_tuser};

    // a rejected step removes nothing
    `SPQ_ASSERT_IMP(a_reject_no_payload,
        m_tvalid && (m_tuser != spq_pkg::ST_OK),
        m_tdata[39:0] == '0,
        "rejected step carries a removed entry")

    // a pop on empty only happens with nothing held
    `SPQ_ASSERT_IMP(a_empty_occ_zero,
        m_tvalid && (m_tuser == spq_pkg::ST_EMPTY),
        occ == '0,
        "empty status with nonzero occupancy")

    // a full reject only happens at capacity
    `SPQ_ASSERT_IMP(a_full_occ_cap,
        m_tvalid && (m_tuser == spq_pkg::ST_FULL),
        occ == cap_wide[spq_pkg::OCC_W-1:0],
        "full status below capacity")

    // one item in work at a time
    `SPQ_ASSERT_NXT(a_one_in_work,
        s_tvalid && s_tready && (in_used || !in_used),
        !s_tready,
        "input accepted while an item is in work")

    // a stalled result holds
    `SPQ_ASSERT_NXT(a_out_hold,
        m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled output transfer changed")

endmodule

bind sorted_priority_queue spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
